/* hdl/fisher_yates_shuffle_engine_defines.svh */
// Assertion macros shared by the shuffle engine modules.
// Depends on nothing; the user module provides the clock and reset signals.
`ifndef FISHER_YATES_SHUFFLE_ENGINE_DEFINES_SVH
`define FISHER_YATES_SHUFFLE_ENGINE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Checked property that is switched off while reset is high.
`define FYSE_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("fyse assertion failed");
// Checked property that also holds during reset.
`define FYSE_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("fyse assertion failed");
`else
`define FYSE_ASSERT(lbl, prop)
`define FYSE_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

/* hdl/fyse_pkg.sv */
// Shared types and constants of the shuffle engine.
// No dependencies; used by the interfaces, the controller, the datapath and the top level.
package fyse_pkg;

   // Element store geometry.
   localparam int STORE_DEPTH   = 1024;
   localparam int ELEMENT_WIDTH = 32;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);

   // Word field widths.
   localparam int CMD_W    = 2;
   localparam int IDX_W    = 10;
   localparam int VALUE_W  = 32;
   localparam int RANDOM_W = 64;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 11;
   localparam int DIV_CNT_W = $clog2(RANDOM_W);

   // Command codes of a request word.
   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD = 2'd0,
      CMD_STEP = 2'd1,
      CMD_READ = 2'd2
   } command_type;

   // Status codes of a response word.
   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE    = 2'd0,
      STAT_SWAPPED = 2'd1,
      STAT_EQUAL   = 2'd2,
      STAT_NOTHING = 2'd3
   } status_code_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_READ,
      ST_DIVIDE,
      ST_SWAP_READ,
      ST_SWAP_POS,
      ST_SWAP_J,
      ST_RESPOND
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic            capture;
      logic            load_write;
      logic            div_step;
      logic            rd_en;
      logic            rd_sel_idx;
      logic            wr_swap_pos;
      logic            wr_swap_j;
      logic            pos_dec;
      logic            out_load;
      logic            out_read;
      status_code_type out_status;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic nothing_to_do;
      logic div_last;
      logic j_eq_pos;
   } dp_status_type;

endpackage

/* hdl/fyse_if.sv */
// Valid/ready channel interfaces for request and response words.
// Depends on fyse_pkg for the field widths.
interface fyse_req_if;
   logic                          valid;
   logic                          ready;
   logic [fyse_pkg::CMD_W-1:0]    command;
   logic [fyse_pkg::IDX_W-1:0]    element_index;
   logic [fyse_pkg::VALUE_W-1:0]  element_value;
   logic [fyse_pkg::RANDOM_W-1:0] random_word;

   modport source (output valid, output command, output element_index,
                   output element_value, output random_word, input ready);
   modport sink (input valid, input command, input element_index,
                 input element_value, input random_word, output ready);
endinterface

interface fyse_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fyse_pkg::VALUE_W-1:0]  read_value;
   logic [fyse_pkg::STATUS_W-1:0] step_status;
   logic [fyse_pkg::IDX_W-1:0]    swap_index;
   logic                          shuffle_done;

   modport source (output valid, output read_value, output step_status,
                   output swap_index, output shuffle_done, input ready);
   modport sink (input valid, input read_value, input step_status,
                 input swap_index, input shuffle_done, output ready);
endinterface

/* hdl/fyse_controller.sv */
// Sequencing state machine of the shuffle engine.
// Depends on fyse_pkg and the assertion macros; drives the datapath by command struct.
`include "fisher_yates_shuffle_engine_defines.svh"

module fyse_controller (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic [fyse_pkg::CMD_W-1:0] req_command,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output fyse_pkg::dp_cmd_type       cmd,
   input  fyse_pkg::dp_status_type    status
);

   fyse_pkg::state_type       state_ff, state_in;
   fyse_pkg::status_code_type resp_status_ff, resp_status_in;
   logic                      resp_read_ff, resp_read_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= fyse_pkg::ST_IDLE;
         resp_status_ff <= fyse_pkg::STAT_DONE;
         resp_read_ff   <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         resp_status_ff <= resp_status_in;
         resp_read_ff   <= resp_read_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in       = state_ff;
      resp_status_in = resp_status_ff;
      resp_read_in   = resp_read_ff;
      cmd            = '0;
      cmd.out_status = resp_status_ff;
      cmd.out_read   = resp_read_ff;
      req_ready      = 1'b0;

      unique case (state_ff)
         fyse_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture    = 1'b1;
               resp_status_in = fyse_pkg::STAT_DONE;
               resp_read_in   = 1'b0;
               unique case (req_command)
                  fyse_pkg::CMD_LOAD: state_in = fyse_pkg::ST_LOAD;
                  fyse_pkg::CMD_STEP: begin
                     if (status.nothing_to_do) begin
                        resp_status_in = fyse_pkg::STAT_NOTHING;
                        state_in       = fyse_pkg::ST_RESPOND;
                     end else begin
                        state_in = fyse_pkg::ST_DIVIDE;
                     end
                  end
                  fyse_pkg::CMD_READ: begin
                     resp_read_in = 1'b1;
                     state_in     = fyse_pkg::ST_READ;
                  end
                  default: state_in = fyse_pkg::ST_RESPOND;
               endcase
            end
         end
         fyse_pkg::ST_LOAD: begin
            cmd.load_write = 1'b1;
            state_in       = fyse_pkg::ST_RESPOND;
         end
         fyse_pkg::ST_READ: begin
            cmd.rd_en      = 1'b1;
            cmd.rd_sel_idx = 1'b1;
            state_in       = fyse_pkg::ST_RESPOND;
         end
         fyse_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = fyse_pkg::ST_SWAP_READ;
            end
         end
         fyse_pkg::ST_SWAP_READ: begin
            // Fetch both entries; an equal index needs no swap at all.
            cmd.rd_en = 1'b1;
            if (status.j_eq_pos) begin
               cmd.pos_dec    = 1'b1;
               resp_status_in = fyse_pkg::STAT_EQUAL;
               state_in       = fyse_pkg::ST_RESPOND;
            end else begin
               resp_status_in = fyse_pkg::STAT_SWAPPED;
               state_in       = fyse_pkg::ST_SWAP_POS;
            end
         end
         fyse_pkg::ST_SWAP_POS: begin
            cmd.wr_swap_pos = 1'b1;
            state_in        = fyse_pkg::ST_SWAP_J;
         end
         fyse_pkg::ST_SWAP_J: begin
            cmd.wr_swap_j = 1'b1;
            cmd.pos_dec   = 1'b1;
            state_in      = fyse_pkg::ST_RESPOND;
         end
         fyse_pkg::ST_RESPOND: begin
            // Wait until the output register is free.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = fyse_pkg::ST_IDLE;
            end
         end
         default: state_in = fyse_pkg::ST_IDLE;
      endcase
   end

   // Response valid flag of the output register.
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `FYSE_ASSERT(a_swap_follows_divide,
      state_ff == fyse_pkg::ST_SWAP_READ |->
      $past(state_ff) == fyse_pkg::ST_DIVIDE && $past(status.div_last))
   `FYSE_ASSERT(a_idle_step_skips,
      state_ff == fyse_pkg::ST_IDLE && req_valid &&
      req_command == fyse_pkg::CMD_STEP && status.nothing_to_do |=>
      state_ff == fyse_pkg::ST_RESPOND && resp_status_ff == fyse_pkg::STAT_NOTHING)
   `FYSE_ASSERT(a_load_only_when_free, cmd.out_load |-> !rsp_valid_ff || rsp_ready)

endmodule

/* hdl/fyse_datapath.sv */
// Datapath of the shuffle engine: element store, serial modulo unit,
// position and count registers, and the response word register.
// Depends on fyse_pkg and the assertion macros.
`include "fisher_yates_shuffle_engine_defines.svh"

module fyse_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [fyse_pkg::COUNT_W-1:0]    csr_write_data,
   input  logic [fyse_pkg::IDX_W-1:0]      req_element_index,
   input  logic [fyse_pkg::VALUE_W-1:0]    req_element_value,
   input  logic [fyse_pkg::RANDOM_W-1:0]   req_random_word,
   input  fyse_pkg::dp_cmd_type            cmd,
   output fyse_pkg::dp_status_type         status,
   output logic [fyse_pkg::VALUE_W-1:0]    rsp_read_value,
   output logic [fyse_pkg::STATUS_W-1:0]   rsp_step_status,
   output logic [fyse_pkg::IDX_W-1:0]      rsp_swap_index,
   output logic                            rsp_shuffle_done
);

   logic [fyse_pkg::ELEMENT_WIDTH-1:0] store_mem [fyse_pkg::STORE_DEPTH];

   logic [fyse_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic [fyse_pkg::IDX_W-1:0]         pos_ff, pos_in;
   logic [fyse_pkg::IDX_W-1:0]         idx_ff;
   logic [fyse_pkg::ELEMENT_WIDTH-1:0] value_ff;
   logic [fyse_pkg::RANDOM_W-1:0]      rnd_ff;
   logic [fyse_pkg::IDX_W-1:0]         rem_ff;
   logic [fyse_pkg::DIV_CNT_W-1:0]     div_cnt_ff;
   logic [fyse_pkg::ELEMENT_WIDTH-1:0] rdata_a_ff, rdata_b_ff;

   logic [fyse_pkg::VALUE_W-1:0]       read_value_ff;
   logic [fyse_pkg::STATUS_W-1:0]      step_status_ff;
   logic [fyse_pkg::IDX_W-1:0]         swap_index_ff;
   logic                               shuffle_done_ff;

   logic [fyse_pkg::COUNT_W-1:0]       count_eff;
   logic [fyse_pkg::IDX_W-1:0]         rearm_pos;
   logic                               in_range;
   logic [fyse_pkg::COUNT_W-1:0]       divisor;
   logic [fyse_pkg::COUNT_W-1:0]       rem_shift;
   logic [fyse_pkg::COUNT_W-1:0]       rem_diff;
   logic [fyse_pkg::IDX_W-1:0]         rem_in;
   logic [fyse_pkg::ADDR_W-1:0]        rd_addr_a;
   logic                               wr_en;
   logic [fyse_pkg::ADDR_W-1:0]        wr_addr;
   logic [fyse_pkg::ELEMENT_WIDTH-1:0] wr_data;

   // Count saturates at the store depth; a load rearms at count minus one.
   always_comb begin
      count_eff = (count_ff > fyse_pkg::COUNT_W'(fyse_pkg::STORE_DEPTH)) ?
                  fyse_pkg::COUNT_W'(fyse_pkg::STORE_DEPTH) : count_ff;
      rearm_pos = (count_eff == '0) ? '0 :
                  fyse_pkg::IDX_W'(count_eff - fyse_pkg::COUNT_W'(1));
      in_range  = {1'b0, idx_ff} < fyse_pkg::COUNT_W'(fyse_pkg::STORE_DEPTH);
   end

   // Count register, written from the configuration port.
   assign count_in = csr_write_enable ? csr_write_data : count_ff;

   // Shuffle position: rearmed by a load, lowered after each step.
   always_comb begin
      priority if (cmd.load_write) begin
         pos_in = rearm_pos;
      end else if (cmd.pos_dec) begin
         pos_in = pos_ff - fyse_pkg::IDX_W'(1);
      end else begin
         pos_in = pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pos_ff   <= '0;
      end else begin
         count_ff <= count_in;
         pos_ff   <= pos_in;
      end
   end

   // Restoring modulo by position plus one, one dividend bit per cycle.
   always_comb begin
      divisor   = {1'b0, pos_ff} + fyse_pkg::COUNT_W'(1);
      rem_shift = {rem_ff, rnd_ff[fyse_pkg::RANDOM_W-1]};
      rem_diff  = rem_shift - divisor;
      rem_in    = (rem_shift >= divisor) ? rem_diff[fyse_pkg::IDX_W-1:0] :
                  rem_shift[fyse_pkg::IDX_W-1:0];
   end

   // Request capture and divider registers.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff     <= req_element_index;
         value_ff   <= fyse_pkg::ELEMENT_WIDTH'(req_element_value);
         rnd_ff     <= req_random_word;
         rem_ff     <= '0;
         div_cnt_ff <= fyse_pkg::DIV_CNT_W'(fyse_pkg::RANDOM_W - 1);
      end else if (cmd.div_step) begin
         rnd_ff     <= {rnd_ff[fyse_pkg::RANDOM_W-2:0], 1'b0};
         rem_ff     <= rem_in;
         div_cnt_ff <= div_cnt_ff - fyse_pkg::DIV_CNT_W'(1);
      end
   end

   // Store port selection: port A reads the index or the position,
   // port B reads the swap index; one write per cycle.
   always_comb begin
      rd_addr_a = cmd.rd_sel_idx ? fyse_pkg::ADDR_W'(idx_ff) : fyse_pkg::ADDR_W'(pos_ff);
      wr_en     = 1'b0;
      wr_addr   = fyse_pkg::ADDR_W'(idx_ff);
      wr_data   = value_ff;
      priority if (cmd.load_write) begin
         wr_en = in_range;
      end else if (cmd.wr_swap_pos) begin
         wr_en   = 1'b1;
         wr_addr = fyse_pkg::ADDR_W'(pos_ff);
         wr_data = rdata_b_ff;
      end else if (cmd.wr_swap_j) begin
         wr_en   = 1'b1;
         wr_addr = fyse_pkg::ADDR_W'(rem_ff);
         wr_data = rdata_a_ff;
      end
   end

   // Element store.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_a_ff <= store_mem[rd_addr_a];
         rdata_b_ff <= store_mem[fyse_pkg::ADDR_W'(rem_ff)];
      end
   end

   // Response word register.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         read_value_ff   <= (cmd.out_read && in_range) ?
                            fyse_pkg::VALUE_W'(rdata_a_ff) : '0;
         step_status_ff  <= cmd.out_status;
         swap_index_ff   <= (cmd.out_status == fyse_pkg::STAT_SWAPPED ||
                             cmd.out_status == fyse_pkg::STAT_EQUAL) ? rem_ff : '0;
         shuffle_done_ff <= (pos_ff == '0);
      end
   end

   assign rsp_read_value   = read_value_ff;
   assign rsp_step_status  = step_status_ff;
   assign rsp_swap_index   = swap_index_ff;
   assign rsp_shuffle_done = shuffle_done_ff;

   // Status toward the controller.
   assign status.nothing_to_do = (count_ff == '0) || (pos_ff == '0);
   assign status.div_last      = (div_cnt_ff == '0);
   assign status.j_eq_pos      = (rem_ff == pos_ff);

   `FYSE_ASSERT(a_rem_below_divisor, cmd.div_step |-> rem_ff <= pos_ff)
   `FYSE_ASSERT(a_swap_needs_distinct, cmd.wr_swap_pos || cmd.wr_swap_j |-> rem_ff != pos_ff)
   `FYSE_ASSERT(a_pos_dec_nonzero, cmd.pos_dec |-> pos_ff != '0 && !cmd.load_write)

endmodule

/* hdl/fisher_yates_shuffle_engine.sv */
// In-place Fisher-Yates shuffle engine over a 1024-entry element store. A word takes
// one command at a time. A step with nothing to do or an unused command goes straight
// to the respond state. A shuffle step runs the serial modulo unit, which reduces the
// 64-bit random word by position plus one one bit per cycle, then the two-entry store
// read and, unless the swap index equals the position, the two write-backs through
// the single write port. The response sits in an output register, so the next word
// is taken while it waits; if a response is still held when the next one is ready,
// the engine holds in its respond state. The user writes the element count through
// the csr port only while the engine is idle; the block itself does not enforce this.
// The store has no reset, so the user must read entries only after they were loaded;
// the block itself does not enforce this either.
// Depends on fyse_pkg, fyse_if, fyse_controller and fyse_datapath.

module fisher_yates_shuffle_engine (
   input  logic                         clock,
   input  logic                         reset,
   fyse_req_if.sink                     req_chan,
   fyse_rsp_if.source                   rsp_chan,
   input  logic                         csr_write_enable,
   input  logic [fyse_pkg::COUNT_W-1:0] csr_write_data
);

   fyse_pkg::dp_cmd_type    dp_cmd;
   fyse_pkg::dp_status_type dp_status;

   // Sequencer.
   fyse_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .cmd         (dp_cmd),
      .status      (dp_status)
   );

   // Store, modulo unit and response register.
   fyse_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_element_index (req_chan.element_index),
      .req_element_value (req_chan.element_value),
      .req_random_word   (req_chan.random_word),
      .cmd               (dp_cmd),
      .status            (dp_status),
      .rsp_read_value    (rsp_chan.read_value),
      .rsp_step_status   (rsp_chan.step_status),
      .rsp_swap_index    (rsp_chan.swap_index),
      .rsp_shuffle_done  (rsp_chan.shuffle_done)
   );

endmodule

/* test/tb_fisher_yates_shuffle_engine.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the Fisher-Yates shuffle engine: loads, shuffle steps and reads.
// Depends on fyse_pkg, fyse_if and the fisher_yates_shuffle_engine top level.

module tb_fisher_yates_shuffle_engine;

   // The command code that the package leaves unused.
   localparam logic [fyse_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int TARGET_WORDS = 1100;
   localparam int QUIET_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 100;

   typedef struct packed {
      logic [fyse_pkg::VALUE_W-1:0] read_value;
      fyse_pkg::status_code_type    step_status;
      logic [fyse_pkg::IDX_W-1:0]   swap_index;
      logic                         shuffle_done;
   } shuffle_result_type;

   // Mirror of the element store and shuffle position, plus the queue of
   // response words still owed by the engine.
   class shuffle_scoreboard;
      bit [fyse_pkg::VALUE_W-1:0] entry_value [fyse_pkg::STORE_DEPTH];
      bit                         entry_loaded [fyse_pkg::STORE_DEPTH];
      bit [fyse_pkg::IDX_W-1:0]   position;
      bit [fyse_pkg::COUNT_W-1:0] element_count;
      shuffle_result_type         owed_results [$];
      int                         errors;

      function void set_count(logic [fyse_pkg::COUNT_W-1:0] value);
         element_count = value;
      endfunction

      // Counts above the store depth saturate.
      function int unsigned active_count();
         return (element_count > fyse_pkg::STORE_DEPTH) ? fyse_pkg::STORE_DEPTH :
                element_count;
      endfunction

      function void note_request(logic [fyse_pkg::CMD_W-1:0] command,
                                 logic [fyse_pkg::IDX_W-1:0] index,
                                 logic [fyse_pkg::VALUE_W-1:0] value,
                                 logic [fyse_pkg::RANDOM_W-1:0] random_word);
         shuffle_result_type            res;
         bit [fyse_pkg::RANDOM_W-1:0]   modulus;
         bit [fyse_pkg::RANDOM_W-1:0]   remainder;
         bit [fyse_pkg::IDX_W-1:0]      pick;
         bit [fyse_pkg::VALUE_W-1:0]    held_value;
         bit                            held_loaded;
         int unsigned                   last;
         res = '0;
         case (command)
            fyse_pkg::CMD_LOAD: begin
               entry_value[index]  = value;
               entry_loaded[index] = 1'b1;
               last = active_count();
               position = (last == 0) ? '0 : fyse_pkg::IDX_W'(last - 1);
            end
            fyse_pkg::CMD_STEP: begin
               if (active_count() == 0 || position == '0) begin
                  res.step_status = fyse_pkg::STAT_NOTHING;
               end else begin
                  modulus   = fyse_pkg::RANDOM_W'(position) + fyse_pkg::RANDOM_W'(1);
                  remainder = random_word % modulus;
                  pick      = remainder[fyse_pkg::IDX_W-1:0];
                  if (pick == position) begin
                     res.step_status = fyse_pkg::STAT_EQUAL;
                  end else begin
                     // Swap the data and whether each entry holds loaded data.
                     held_value             = entry_value[position];
                     held_loaded            = entry_loaded[position];
                     entry_value[position]  = entry_value[pick];
                     entry_loaded[position] = entry_loaded[pick];
                     entry_value[pick]      = held_value;
                     entry_loaded[pick]     = held_loaded;
                     res.step_status = fyse_pkg::STAT_SWAPPED;
                  end
                  res.swap_index = pick;
                  position = position - fyse_pkg::IDX_W'(1);
               end
            end
            fyse_pkg::CMD_READ: begin
               res.read_value = entry_value[index];
            end
            default: begin
               // The unused command changes nothing.
            end
         endcase
         res.shuffle_done = (position == '0);
         owed_results.push_back(res);
      endfunction

      function void check_response(logic [fyse_pkg::VALUE_W-1:0] read_value,
                                   logic [fyse_pkg::STATUS_W-1:0] step_status,
                                   logic [fyse_pkg::IDX_W-1:0] swap_index,
                                   logic shuffle_done);
         shuffle_result_type want;
         if (owed_results.size() == 0) begin
            $display("%0t: response word with no request owed: read_value %h status %0d",
                     $time, read_value, step_status);
            errors++;
            return;
         end
         want = owed_results.pop_front();
         if (read_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h", $time, want.read_value,
                     read_value);
            errors++;
         end
         if (step_status !== want.step_status) begin
            $display("%0t: step_status expected %0d actual %0d", $time, want.step_status,
                     step_status);
            errors++;
         end
         if (swap_index !== want.swap_index) begin
            $display("%0t: swap_index expected %0d actual %0d", $time, want.swap_index,
                     swap_index);
            errors++;
         end
         if (shuffle_done !== want.shuffle_done) begin
            $display("%0t: shuffle_done expected %b actual %b", $time, want.shuffle_done,
                     shuffle_done);
            errors++;
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         csr_write_enable;
   logic [fyse_pkg::COUNT_W-1:0] csr_write_data;

   fyse_req_if req_chan();
   fyse_rsp_if rsp_chan();

   shuffle_scoreboard scoreboard = new();
   int words_sent   = 0;
   int quiet_cycles = 0;
   bit no_gaps      = 1'b0;

   fisher_yates_shuffle_engine i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Observe register writes and both channels at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable) begin
            scoreboard.set_count(csr_write_data);
         end
         if (req_chan.valid && req_chan.ready) begin
            scoreboard.note_request(req_chan.command, req_chan.element_index,
                                    req_chan.element_value, req_chan.random_word);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            scoreboard.check_response(rsp_chan.read_value, rsp_chan.step_status,
                                      rsp_chan.swap_index, rsp_chan.shuffle_done);
         end
      end
   end

   // Watchdog on cycles in which nothing moves.
   always @(posedge clock) begin
      if (reset || csr_write_enable || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // The receiver stalls in about a fifth of the cycles, outside the no-gap stretch.
   always @(negedge clock) begin
      rsp_chan.ready <= no_gaps || ($urandom_range(0, 99) >= 20);
   end

   // Present one word, with an occasional gap before it, and wait for it to be taken.
   task automatic send_word(input logic [fyse_pkg::CMD_W-1:0] command,
                            input logic [fyse_pkg::IDX_W-1:0] index,
                            input logic [fyse_pkg::VALUE_W-1:0] value,
                            input logic [fyse_pkg::RANDOM_W-1:0] random_word);
      int gap;
      gap = 0;
      no_gaps = (words_sent >= 400 && words_sent < 600);
      if (!no_gaps && $urandom_range(0, 99) < 20) begin
         gap = $urandom_range(1, 4);
      end
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid         <= 1'b1;
      req_chan.command       <= command;
      req_chan.element_index <= index;
      req_chan.element_value <= value;
      req_chan.random_word   <= random_word;
      do @(posedge clock); while (!req_chan.ready);
      if (command != CMD_UNUSED) begin
         words_sent++;
      end
      @(negedge clock);
   endtask

   // Hold the sender until every owed response has come back.
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (scoreboard.owed_results.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_count(input logic [fyse_pkg::COUNT_W-1:0] count_value);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= count_value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Random words that favor the edges of the modulo and the equal-index case.
   function automatic logic [fyse_pkg::RANDOM_W-1:0] step_random();
      logic [fyse_pkg::RANDOM_W-1:0] word;
      word = '0;
      case ($urandom_range(0, 9))
         0: word = '1;
         1: word = '0;
         2: word[fyse_pkg::IDX_W-1:0] = scoreboard.position;
         3, 4: word = fyse_pkg::RANDOM_W'($urandom_range(0, 2047));
         default: word = {$urandom, $urandom};
      endcase
      return word;
   endfunction

   function automatic logic [fyse_pkg::VALUE_W-1:0] element_data();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // A random entry that holds loaded data, or -1 when there is none.
   function automatic int loaded_index();
      int picks [$];
      foreach (scoreboard.entry_loaded[i]) begin
         if (scoreboard.entry_loaded[i]) picks.push_back(i);
      end
      if (picks.size() == 0) return -1;
      return picks[$urandom_range(0, picks.size() - 1)];
   endfunction

   task automatic read_some(input int reads);
      int index;
      repeat (reads) begin
         index = loaded_index();
         if (index >= 0) begin
            send_word(fyse_pkg::CMD_READ, fyse_pkg::IDX_W'(index), $urandom,
                      {$urandom, $urandom});
         end
      end
   endtask

   // Out-of-sequence words: unused command, stray read, rearming load or stray step.
   task automatic send_noise();
      int index;
      case ($urandom_range(0, 3))
         0: send_word(CMD_UNUSED, fyse_pkg::IDX_W'($urandom), $urandom,
                      {$urandom, $urandom});
         1: read_some(1);
         2: begin
            index = $urandom_range(0, fyse_pkg::STORE_DEPTH - 1);
            send_word(fyse_pkg::CMD_LOAD, fyse_pkg::IDX_W'(index), element_data(),
                      {$urandom, $urandom});
         end
         default: send_word(fyse_pkg::CMD_STEP, fyse_pkg::IDX_W'($urandom), $urandom,
                            step_random());
      endcase
   endtask

   // One shuffle run: set the count, usually load, step (to the end for at most 24 entries), read back.
   task automatic run_phase();
      int unsigned count_value;
      int unsigned active;
      int unsigned loads;
      int unsigned steps;
      int          index;
      int          pick;
      pick = $urandom_range(0, 99);
      if (pick < 4) count_value = 0;
      else if (pick < 8) count_value = 1;
      else if (pick < 12) count_value = fyse_pkg::STORE_DEPTH;
      else if (pick < 15) count_value = 2047;
      else if (pick < 20) count_value = $urandom_range(17, 2047);
      else count_value = $urandom_range(2, 16);
      write_count(fyse_pkg::COUNT_W'(count_value));
      active = (count_value > fyse_pkg::STORE_DEPTH) ? fyse_pkg::STORE_DEPTH : count_value;

      // Some runs skip the loads and keep the position left by the last one.
      if ($urandom_range(0, 99) >= 15) begin
         loads = (active == 0) ? 2 : ((active > 24) ? 24 : active);
         for (int i = 0; i < loads; i++) begin
            index = (active > 24) ? $urandom_range(0, fyse_pkg::STORE_DEPTH - 1) : i;
            send_word(fyse_pkg::CMD_LOAD, fyse_pkg::IDX_W'(index), element_data(),
                      {$urandom, $urandom});
         end
      end

      steps = (active <= 24) ? active + 1 : $urandom_range(10, 30);
      repeat (steps) begin
         if ($urandom_range(0, 99) < 10) send_noise();
         send_word(fyse_pkg::CMD_STEP, fyse_pkg::IDX_W'($urandom), $urandom, step_random());
      end

      read_some($urandom_range(2, 12));
      if ($urandom_range(0, 99) < 10) begin
         repeat (3) send_noise();
      end
   endtask

   initial begin
      reset                  = 1'b1;
      csr_write_enable       = 1'b0;
      csr_write_data         = '0;
      req_chan.valid         = 1'b0;
      req_chan.command       = fyse_pkg::CMD_LOAD;
      req_chan.element_index = '0;
      req_chan.element_value = '0;
      req_chan.random_word   = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Zero count: steps have nothing to do and a load leaves the position at zero.
      write_count('0);
      send_word(fyse_pkg::CMD_STEP, '0, '0, {$urandom, $urandom});
      send_word(CMD_UNUSED, '0, '0, '0);
      send_word(fyse_pkg::CMD_LOAD, '0, '1, '0);
      send_word(fyse_pkg::CMD_READ, '0, '0, '0);
      send_word(fyse_pkg::CMD_STEP, '0, '0, '1);

      // Saturated count: the position arms at the top of the store.
      write_count(fyse_pkg::COUNT_W'(2047));
      send_word(fyse_pkg::CMD_LOAD, fyse_pkg::IDX_W'(fyse_pkg::STORE_DEPTH - 1), '0, '1);
      send_word(fyse_pkg::CMD_LOAD, fyse_pkg::IDX_W'(fyse_pkg::STORE_DEPTH - 2),
                32'hA5A5_5A5A, '0);
      send_word(CMD_UNUSED, '1, '1, '1);
      send_word(fyse_pkg::CMD_STEP, '1, '1, '1);
      send_word(fyse_pkg::CMD_STEP, '0, '0, '0);
      send_word(fyse_pkg::CMD_READ, '0, '0, '0);
      send_word(fyse_pkg::CMD_READ, fyse_pkg::IDX_W'(fyse_pkg::STORE_DEPTH - 2), '0, '0);
      send_word(fyse_pkg::CMD_READ, fyse_pkg::IDX_W'(fyse_pkg::STORE_DEPTH - 1), '1, '1);

      // A new count keeps the old position until the next load rearms it.
      write_count(fyse_pkg::COUNT_W'(3));
      send_word(fyse_pkg::CMD_STEP, '0, '0, 64'd5);
      send_word(fyse_pkg::CMD_LOAD, fyse_pkg::IDX_W'(0), 32'h0000_0011, '0);
      send_word(fyse_pkg::CMD_LOAD, fyse_pkg::IDX_W'(1), 32'h0000_0022, '0);
      send_word(fyse_pkg::CMD_LOAD, fyse_pkg::IDX_W'(2), 32'h0000_0033, '0);
      send_word(fyse_pkg::CMD_STEP, '0, '0, 64'd2);
      send_word(fyse_pkg::CMD_STEP, '0, '0, 64'd1);
      send_word(fyse_pkg::CMD_STEP, '0, '0, '1);
      send_word(fyse_pkg::CMD_READ, fyse_pkg::IDX_W'(0), '0, '0);
      send_word(fyse_pkg::CMD_READ, fyse_pkg::IDX_W'(1), '0, '0);
      send_word(fyse_pkg::CMD_READ, fyse_pkg::IDX_W'(2), '0, '0);

      while (words_sent < TARGET_WORDS) run_phase();

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (scoreboard.errors == 0 && scoreboard.owed_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hdl
hdl/fyse_pkg.sv
hdl/fyse_if.sv
hdl/fyse_controller.sv
hdl/fyse_datapath.sv
hdl/fisher_yates_shuffle_engine.sv
test/tb_fisher_yates_shuffle_engine.sv
